// File: src/dls_pkg.sv
// ----------------------------------------------------------------------------
// dls_pkg: shared types and constants
// Fixed sizes, field codes and the command word passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none
package dls_pkg;
  localparam int unsigned NODES   = 16;
  localparam int unsigned INPUTS  = 64;
  localparam int unsigned DW      = 16;
  localparam int unsigned NODE_W  = 4;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned FRAC_W  = 12;
  localparam int unsigned QUO_W   = 15;
  localparam int unsigned S_W     = SUM_W + 1;
  localparam int unsigned WADDR_W = NODE_W + POS_W;

  localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

  // input kind codes
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_WEIGHT = 2'd1;
  localparam logic [1:0] KIND_BIAS   = 2'd2;

  // configuration register indexes
  localparam logic CFG_NODES  = 1'b0;
  localparam logic CFG_INPUTS = 1'b1;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_WEIGHT,
    OP_BIAS
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [NODE_W-1:0]  node;
    logic [POS_W-1:0]   pos;
    logic [DW-1:0]      value;
    logic               acc;
    logic               last;
    logic               mismatch;
    logic [NODE_W-1:0]  last_node;
  } cmd_t;
endpackage
`default_nettype wire

// File: src/dls_if.sv
// ----------------------------------------------------------------------------
// dls_in_if / dls_out_if: request channels
// Valid/ready channels for input requests and node results.
// ----------------------------------------------------------------------------
`default_nettype none
interface dls_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  node_index;
  logic [5:0]  input_index;
  logic signed [15:0] value;
  logic        last;
  modport source (output valid, kind, node_index, input_index, value, last, input ready);
  modport sink   (input valid, kind, node_index, input_index, value, last, output ready);
endinterface

interface dls_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  node_number;
  logic signed [15:0] activation;
  logic        size_mismatch;
  logic        end_of_vector;
  modport source (output valid, node_number, activation, size_mismatch, end_of_vector,
                  input ready);
  modport sink   (input valid, node_number, activation, size_mismatch, end_of_vector,
                  output ready);
endinterface
`default_nettype wire

// File: src/dense_layer_softsign_core.sv
// ----------------------------------------------------------------------------
// dense_layer_softsign_core: fully connected layer, soft-sign output
// Top level: request intake, command queue and execution unit.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries requests: weight writes, bias writes and samples (Q4.12).
//   out_o carries one result per node in use after a sample marked last,
//   Q1.15 activation, end_of_vector on the final node.
//   cfg_we_i/cfg_idx_i/cfg_data_i write nodes_in_use (0) or inputs_in_use (1)
//   while the block is idle.
// Sequence:
//   Weight and bias writes finish as the execution unit takes them from
//   the queue. A sample is taken from the queue, then the shared MAC visits
//   one node per cycle over all 16 nodes and a drain step waits while the
//   two-stage multiply pipeline empties. After a last sample each node passes
//   three setup steps, 15 divider steps and an output step that waits on stalls.
//   A two-entry queue lets intake run ahead of execution.
// Reset clears the sums, sample count and configuration (16 nodes, 64
//   inputs); weights and biases must be written before use.
// A stalled receiver holds the result; the queue then fills and in_i.ready
//   drops.
// ----------------------------------------------------------------------------
`default_nettype none
module dense_layer_softsign_core
  import dls_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [6:0] cfg_data_i,
  dls_in_if.sink          in_i,
  dls_out_if.source       out_o
);
  cmd_t f_cmd, q_cmd;
  logic push, full, pop, q_valid;

  dls_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i, .cmd_o(f_cmd), .push_o(push), .full_i(full)
  );

  dls_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(f_cmd), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .data_o(q_cmd)
  );

  dls_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .cmd_i(q_cmd), .pop_o(pop), .out_o
  );
endmodule
`default_nettype wire

// File: src/dls_front.sv
// ----------------------------------------------------------------------------
// dls_front: request intake
// Holds configuration and the sample count, turns requests into commands.
// ----------------------------------------------------------------------------
`default_nettype none
module dls_front
  import dls_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [6:0]  cfg_data_i,
  dls_in_if.sink           in_i,
  output cmd_t             cmd_o,
  output logic             push_o,
  input  wire logic        full_i
);
  logic [4:0]       nodes_q;
  logic [CNT_W-1:0] inputs_q;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic             accept;
  logic [4:0]       used;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = accept && (in_i.kind != 2'd3);

  // saturating sample count
  assign cnt_inc = (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + 7'd1;

  // clamp node count to 1..NODES
  always_comb begin
    used = nodes_q;
    if (nodes_q == 5'd0) used = 5'd1;
    else if (nodes_q > 5'(NODES)) used = 5'(NODES);
  end

  // command build
  always_comb begin
    cmd_o.node      = in_i.node_index;
    cmd_o.pos       = in_i.input_index;
    cmd_o.value     = in_i.value;
    cmd_o.acc       = cnt_q < 7'(INPUTS);
    cmd_o.last      = in_i.last;
    cmd_o.mismatch  = (cnt_inc != inputs_q) || (cnt_inc > 7'(INPUTS));
    cmd_o.last_node = NODE_W'(used - 5'd1);
    case (in_i.kind)
      KIND_WEIGHT: cmd_o.op = OP_WEIGHT;
      KIND_BIAS:   cmd_o.op = OP_BIAS;
      default: begin
        cmd_o.op  = OP_SAMPLE;
        cmd_o.pos = cnt_q[POS_W-1:0];
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept && in_i.kind == KIND_SAMPLE) cnt_d = in_i.last ? '0 : cnt_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_q  <= 5'd16;
      inputs_q <= 7'd64;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_NODES) nodes_q <= cfg_data_i[4:0];
        else inputs_q <= cfg_data_i;
      end
    end
  end
endmodule
`default_nettype wire

// File: src/dls_fifo.sv
// ----------------------------------------------------------------------------
// dls_fifo: command queue
// Two-entry queue between intake and execution.
// ----------------------------------------------------------------------------
`default_nettype none
module dls_fifo
  import dls_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      data_o
);
  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule
`default_nettype wire

// File: src/dls_back.sv
// ----------------------------------------------------------------------------
// dls_back: execution unit
// Weight memory, bias registers, shared MAC over the nodes and the
// soft-sign divider that produces the node results.
// ----------------------------------------------------------------------------
`default_nettype none
module dls_back
  import dls_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  input  cmd_t      cmd_i,
  output logic      pop_o,
  dls_out_if.source out_o
);
  typedef enum logic [2:0] {
    B_IDLE, B_MAC, B_DRAIN, B_SUM, B_MAG, B_DEN, B_DIV, B_OUT
  } state_e;

  state_e              state_q;
  cmd_t                cmd_q;
  logic [NODE_W-1:0]   n_q;
  logic [DW-1:0]       wmem [NODES*INPUTS];
  logic [DW-1:0]       wdata_q;
  logic [DW-1:0]       bias_q [NODES];
  logic [SUM_W-1:0]    sums_q [NODES];
  logic                s1_v_q, s2_v_q;
  logic [NODE_W-1:0]   s1_n_q, s2_n_q;
  logic signed [2*DW-1:0] prod_q;
  logic [S_W-1:0]      s_q;
  logic                neg_q;
  logic [SUM_W-1:0]    mag_q;
  logic [S_W-1:0]      den_q, rem_q;
  logic [QUO_W-1:0]    quo_q;
  logic [3:0]          step_q;
  logic                out_v_q;
  logic [15:0]         act_q;
  logic                clr;
  logic [SUM_W-1:0]    sum_sel;
  logic [S_W:0]        r2;
  logic                ge;
  logic [QUO_W-1:0]    quo_f;
  logic [DW-1:0]       bias_n;

  assign pop_o = (state_q == B_IDLE) && valid_i;
  assign clr   = (state_q == B_OUT) && out_o.ready && (n_q == cmd_q.last_node);

  assign out_o.valid         = out_v_q;
  assign out_o.node_number   = n_q;
  assign out_o.activation    = act_q;
  assign out_o.size_mismatch = cmd_q.mismatch;
  assign out_o.end_of_vector = n_q == cmd_q.last_node;

  // weight memory: write on pop, registered read by the MAC issue
  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.op == OP_WEIGHT) wmem[{cmd_i.node, cmd_i.pos}] <= cmd_i.value;
    wdata_q <= wmem[{n_q, cmd_q.pos}];
    if (pop_o && cmd_i.op == OP_BIAS) bias_q[cmd_i.node] <= cmd_i.value;
    prod_q <= $signed(wdata_q) * $signed(cmd_q.value);
  end

  // node accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) sums_q[i] <= '0;
    end else if (clr) begin
      for (int i = 0; i < NODES; i++) sums_q[i] <= '0;
    end else if (s2_v_q) begin
      sums_q[s2_n_q] <= sums_q[s2_n_q] + SUM_W'(prod_q);
    end
  end

  // divider datapath
  assign sum_sel = cmd_q.mismatch ? '0 : sums_q[n_q];
  assign bias_n  = bias_q[n_q];
  assign r2      = {rem_q, 1'b0};
  assign ge      = r2 >= {1'b0, den_q};
  assign quo_f   = {quo_q[QUO_W-2:0], ge};

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cmd_q   <= '0;
      n_q     <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s1_n_q  <= '0;
      s2_n_q  <= '0;
      out_v_q <= 1'b0;
      step_q  <= '0;
    end else begin
      s1_v_q <= (state_q == B_MAC);
      s1_n_q <= n_q;
      s2_v_q <= s1_v_q;
      s2_n_q <= s1_n_q;
      unique case (state_q)
        B_IDLE: begin
          if (valid_i) begin
            cmd_q <= cmd_i;
            n_q   <= '0;
            if (cmd_i.op == OP_SAMPLE) state_q <= cmd_i.acc ? B_MAC : B_DRAIN;
          end
        end
        B_MAC: begin
          n_q <= n_q + 1'b1;
          if (n_q == NODE_W'(NODES-1)) state_q <= B_DRAIN;
        end
        B_DRAIN: begin
          n_q <= '0;
          if (!s1_v_q && !s2_v_q) state_q <= cmd_q.last ? B_SUM : B_IDLE;
        end
        B_SUM: begin
          s_q <= {sum_sel[SUM_W-1], sum_sel}
                 - {{(S_W-DW-FRAC_W){bias_n[DW-1]}}, bias_n, {FRAC_W{1'b0}}};
          state_q <= B_MAG;
        end
        B_MAG: begin
          neg_q   <= s_q[S_W-1];
          mag_q   <= s_q[S_W-1] ? SUM_W'(-s_q) : s_q[SUM_W-1:0];
          state_q <= B_DEN;
        end
        B_DEN: begin
          den_q   <= {1'b0, mag_q} + (S_W'(1) << 24);
          rem_q   <= {1'b0, mag_q};
          quo_q   <= '0;
          step_q  <= '0;
          state_q <= B_DIV;
        end
        B_DIV: begin
          rem_q  <= ge ? S_W'(r2 - {1'b0, den_q}) : r2[S_W-1:0];
          quo_q  <= quo_f;
          step_q <= step_q + 4'd1;
          if (step_q == 4'(QUO_W-1)) begin
            act_q   <= neg_q ? 16'(-{1'b0, quo_f}) : {1'b0, quo_f};
            out_v_q <= 1'b1;
            state_q <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_o.ready) begin
            out_v_q <= 1'b0;
            if (n_q == cmd_q.last_node) state_q <= B_IDLE;
            else begin
              n_q     <= n_q + 1'b1;
              state_q <= B_SUM;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: src/dls_checker.sv
// ----------------------------------------------------------------------------
// dls_checker: port assertions
// Checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module dls_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [3:0]  out_node_i,
  input wire logic [15:0] out_act_i,
  input wire logic        out_eov_i
);
  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_act_i) && $stable(out_node_i))
    else $error("stalled result changed");

  // highest node is always the end of the vector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_node_i == 4'd15 |-> out_eov_i)
    else $error("node 15 without end_of_vector");

  // soft-sign magnitude stays below one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_act_i != 16'h8000)
    else $error("activation out of range");
endmodule

bind dense_layer_softsign_core dls_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready),
  .out_node_i(out_o.node_number), .out_act_i(out_o.activation),
  .out_eov_i(out_o.end_of_vector)
);
`default_nettype wire

// File: verif/dense_layer_softsign_core_checker.sv
// ----------------------------------------------------------------------------
// dense_layer_softsign_core_checker: result predictor and scoreboard
// Watches the request and result channels and the register port, keeps its
// own weights, biases, node sums and sample count, and compares every result
// with the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none
module dense_layer_softsign_core_checker
  import dls_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [6:0] cfg_data_i,
  dls_in_if               req_mon,
  dls_out_if              res_mon,
  output int              fail_count_o,
  output int              pending_o
);

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [DW-1:0]     act;
    logic              mism;
    logic              eov;
  } node_result_t;

  logic signed [DW-1:0] weights [NODES*INPUTS];
  logic signed [DW-1:0] biases  [NODES];
  logic [SUM_W-1:0]     node_sums [NODES];
  logic [CNT_W-1:0]     sample_cnt;
  logic [4:0]           nodes_cfg;
  logic [6:0]           inputs_cfg;
  node_result_t         expected_acts [$];
  int                   fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_acts.size();

  // soft-sign in Q1.15, truncated toward zero
  function automatic logic [DW-1:0] softsign_q15(longint s);
    longint unsigned mag, q;
    mag = (s < 0) ? longint'(-s) : s;
    q   = (mag << 15) / ((64'd1 << 24) + mag);
    return (s < 0) ? DW'(-q) : DW'(q);
  endfunction

  // fold one sample into every node sum; on last, queue the node results
  task automatic take_sample(logic signed [DW-1:0] x, logic lst);
    logic   mism;
    int     used;
    longint s;
    node_result_t r;
    if (sample_cnt < INPUTS) begin
      for (int n = 0; n < NODES; n++) begin
        node_sums[n] = node_sums[n] +
                       SUM_W'(longint'(x) * longint'(weights[n*INPUTS + sample_cnt]));
      end
    end
    if (sample_cnt < CNT_MAX) sample_cnt = sample_cnt + 1'b1;
    if (!lst) return;
    mism = (sample_cnt != inputs_cfg) || (sample_cnt > INPUTS);
    used = (nodes_cfg == 0) ? 1 : (nodes_cfg > NODES) ? NODES : int'(nodes_cfg);
    for (int n = 0; n < used; n++) begin
      s = mism ? 0 : longint'($signed(node_sums[n]));
      s = s - longint'(biases[n]) * (64'sd1 <<< FRAC_W);
      r.node = NODE_W'(n);
      r.act  = softsign_q15(s);
      r.mism = mism;
      r.eov  = (n == used - 1);
      expected_acts.push_back(r);
    end
    for (int n = 0; n < NODES; n++) node_sums[n] = '0;
    sample_cnt = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NODES; n++) node_sums[n] = '0;
      sample_cnt = '0;
      nodes_cfg  = 5'd16;
      inputs_cfg = 7'd64;
      expected_acts.delete();
      fails      = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_NODES) nodes_cfg = cfg_data_i[4:0];
        else inputs_cfg = cfg_data_i;
      end
      // accepted request
      if (req_mon.valid && req_mon.ready) begin
        case (req_mon.kind)
          KIND_WEIGHT: weights[{req_mon.node_index, req_mon.input_index}] = req_mon.value;
          KIND_BIAS:   biases[req_mon.node_index] = req_mon.value;
          KIND_SAMPLE: take_sample(req_mon.value, req_mon.last);
          default: ;
        endcase
      end
      // accepted result
      if (res_mon.valid && res_mon.ready) begin
        if (expected_acts.size() == 0) begin
          $error("unexpected result: node %0d activation %0d", res_mon.node_number,
                 res_mon.activation);
          fails++;
        end else begin
          node_result_t e;
          e = expected_acts.pop_front();
          if (res_mon.node_number !== e.node) begin
            $error("node_number: expected %0d actual %0d", e.node, res_mon.node_number);
            fails++;
          end
          if (res_mon.activation !== e.act) begin
            $error("activation: expected %0d actual %0d", $signed(e.act),
                   res_mon.activation);
            fails++;
          end
          if (res_mon.size_mismatch !== e.mism) begin
            $error("size_mismatch: expected %0d actual %0d", e.mism, res_mon.size_mismatch);
            fails++;
          end
          if (res_mon.end_of_vector !== e.eov) begin
            $error("end_of_vector: expected %0d actual %0d", e.eov, res_mon.end_of_vector);
            fails++;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: verif/dense_layer_softsign_core_test.sv
// ----------------------------------------------------------------------------
// dense_layer_softsign_core_test: stimulus and verdict
// Loads the weights of the first input positions and every bias, then runs
// short sample vectors under several layer sizes with random gaps on both
// channels and one long receiver stall; the checker beside the block
// predicts and compares the node results.
// ----------------------------------------------------------------------------
`default_nettype none
module dense_layer_softsign_core_test;
  import dls_pkg::*;

  // input positions whose weights are loaded; vectors never go past them
  localparam int LIVE_POS = 4;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [6:0] cfg_data_i;
  int         fail_count;
  int         pending;
  bit         quiet;
  int         hold_tokens;
  int         vector_total;
  int         sample_total;

  dls_in_if  req_if ();
  dls_out_if res_if ();

  dense_layer_softsign_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if),
    .out_o      (res_if)
  );

  dense_layer_softsign_core_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .req_mon      (req_if),
    .res_mon      (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit
  initial begin
    #5_000_000;
    $display("dense_layer_softsign_core_test: errors");
    $finish;
  end

  // result receiver: random stall bursts, long hold-offs on request
  initial begin
    int holds_done;
    int n;
    holds_done   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_tokens > holds_done) begin
        holds_done++;
        res_if.ready = 1'b0;
        repeat (400) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        res_if.ready = 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        res_if.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 20)) @(negedge clk_i);
      end
    end
  end

  // one request; returns once accepted
  task automatic put_req(logic [1:0] k, logic [3:0] nd, logic [5:0] ps,
                         logic [15:0] v, logic lst);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk_i);
      req_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid       = 1'b1;
    req_if.kind        = k;
    req_if.node_index  = nd;
    req_if.input_index = ps;
    req_if.value       = v;
    req_if.last        = lst;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // a sample vector, with noise requests mixed in
  task automatic send_vector(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: put_req(2'd3, 4'($urandom), 6'($urandom), 16'($urandom), 1'($urandom));
          1: put_req(KIND_BIAS, 4'($urandom), 6'($urandom), pick_value(), 1'($urandom));
          default: put_req(KIND_WEIGHT, 4'($urandom), 6'($urandom), pick_value(),
                           1'($urandom));
        endcase
      end
      put_req(KIND_SAMPLE, 4'($urandom), 6'($urandom), pick_value(), i == len - 1);
      sample_total++;
    end
    vector_total++;
  endtask

  // drop the request line, let all results drain, then the trailing work
  task automatic drain();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_layer(logic [6:0] nodes, logic [6:0] inputs);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = CFG_NODES; cfg_data_i = nodes;
    @(negedge clk_i);
    cfg_idx_i = CFG_INPUTS; cfg_data_i = inputs;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    int len;
    int limit;
    logic [6:0] phase_nodes  [6] = '{7'd1, 7'd0, 7'd31, 7'd5, 7'd16, 7'd9};
    logic [6:0] phase_inputs [6] = '{7'd1, 7'd4, 7'd3, 7'd2, 7'd4, 7'd127};
    quiet        = 1'b0;
    hold_tokens  = 0;
    vector_total = 0;
    sample_total = 0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_NODES;
    cfg_data_i   = '0;
    req_if.valid = 1'b0;
    req_if.kind  = KIND_SAMPLE;
    req_if.node_index  = '0;
    req_if.input_index = '0;
    req_if.value = '0;
    req_if.last  = 1'b0;
    rst_ni       = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill the weights of the live positions and every bias
    for (int n = 0; n < NODES; n++)
      for (int p = 0; p < LIVE_POS; p++)
        put_req(KIND_WEIGHT, 4'(n), 6'(p), pick_value(), 1'(p));
    for (int n = 0; n < NODES; n++) put_req(KIND_BIAS, 4'(n), '0, pick_value(), 1'b0);

    // directed: short vector at reset sizes (size mismatch), extreme samples
    for (int i = 0; i < LIVE_POS; i++)
      put_req(KIND_SAMPLE, '0, '0, (i % 2) ? 16'h8000 : 16'h7FFF, i == LIVE_POS - 1);
    vector_total++; sample_total += LIVE_POS;
    put_req(2'd3, 4'hF, 6'h3F, 16'hFFFF, 1'b1);
    put_req(KIND_BIAS, 4'd0, 6'h3F, 16'h8000, 1'b1);
    put_req(KIND_BIAS, 4'd15, '0, 16'h7FFF, 1'b0);
    send_vector(3);     // short vector, size mismatch
    drain();

    // random phases over several layer sizes
    foreach (phase_nodes[p]) begin
      set_layer(phase_nodes[p], phase_inputs[p]);
      if (p == 3) hold_tokens++;
      if (p == 5) quiet = 1'b1;
      limit = 6;
      for (int v = 0; v < limit; v++) begin
        len = ($urandom_range(0, 4) != 0) ? int'(phase_inputs[p])
                                          : $urandom_range(1, LIVE_POS);
        if (len > LIVE_POS) len = LIVE_POS;
        send_vector(len);
      end
      drain();
    end

    @(negedge clk_i);
    req_if.valid = 1'b0;
    drain();
    $display("covered %0d vectors, %0d samples, 7 layer sizes, one long stall",
             vector_total, sample_total);
    if (fail_count == 0 && pending == 0) begin
      $display("dense_layer_softsign_core_test: clean");
    end else begin
      $display("dense_layer_softsign_core_test: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
